// ===== hdl/pbd_pkg.sv =====
package pbd_pkg;

	localparam int unsigned ROUND_COUNT_DEF  = 10;
	localparam int unsigned RETRY_BLOCKS_DEF = 256;

	localparam logic [31:0] MULT_A = 32'hd2511f53;
	localparam logic [31:0] MULT_B = 32'hcd9e8d57;
	localparam logic [31:0] WEYL_A = 32'h9e3779b9;
	localparam logic [31:0] WEYL_B = 32'hbb67ae85;

	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [0:0] {
		OP_RAW     = 1'b0,
		OP_BOUNDED = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO      = 2'd1,
		ST_EXHAUSTED = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_LOW  = 3'd0,
		REG_KEY_HIGH = 3'd1,
		REG_BASE_A   = 3'd2,
		REG_BASE_B   = 3'd3,
		REG_BASE_C   = 3'd4,
		REG_BASE_D   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLS_RAW,
		CLS_ZERO,
		CLS_BOUNDED
	} cls_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_THR,
		S_ROUND,
		S_PICK,
		S_MOD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic        operation;
		logic [63:0] sample_index;
		logic [31:0] draw_site;
		logic [31:0] draw_limit;
	} cmd_t;

	typedef struct packed {
		logic [31:0] draw_value;
		logic [1:0]  status;
	} result_t;

	typedef struct packed {
		cls_t cls;
		cmd_t cmd;
	} job_t;

	typedef struct packed {
		logic [31:0] key_low;
		logic [31:0] key_high;
		logic [31:0] base_a;
		logic [31:0] base_b;
		logic [31:0] base_c;
		logic [31:0] base_d;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

endpackage

// ===== hdl/philox_bounded_draw_unit.sv =====
// counter-based random draw unit (philox 4x32). start is taken when busy is low;
// each item yields exactly one result on result, marked by a one-cycle done strobe
// that cannot be held off. a two-entry queue sits between the classifying front end
// and the execution engine, so up to two items may be taken while one is in work.
// a raw draw runs ROUND_COUNT philox rounds in the engine and then picks a lane;
// a bounded draw first finds the 2^32 mod bound threshold, then runs ROUND_COUNT
// rounds per retry block tried until a lane reaches the threshold, then takes the
// final mod. the engine has a single philox round unit and a bit-serial remainder
// unit. a zero bound returns status 1, and exhausting every retry block returns
// status 2 with value 0. the user must write the key and counter base registers
// through cfg_valid/cfg_index/cfg_data only while the unit is idle; the unit does
// not enforce this. cfg_ready is always high and unknown indexes are dropped
module philox_bounded_draw_unit #(
	parameter int unsigned ROUND_COUNT  = pbd_pkg::ROUND_COUNT_DEF,
	parameter int unsigned RETRY_BLOCKS = pbd_pkg::RETRY_BLOCKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  pbd_pkg::cmd_t                     cmd,
	output logic                              done,
	output pbd_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pbd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);

	pbd_pkg::cfg_t   cfg_q;
	pbd_pkg::qstat_t qstat;
	pbd_pkg::job_t   push_job;
	pbd_pkg::job_t   pop_job;
	logic            push;
	logic            pop;

	assign cfg_ready = 1'b1;

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pbd_pkg::REG_KEY_LOW:  cfg_q.key_low  <= cfg_data;
				pbd_pkg::REG_KEY_HIGH: cfg_q.key_high <= cfg_data;
				pbd_pkg::REG_BASE_A:   cfg_q.base_a   <= cfg_data;
				pbd_pkg::REG_BASE_B:   cfg_q.base_b   <= cfg_data;
				pbd_pkg::REG_BASE_C:   cfg_q.base_c   <= cfg_data;
				pbd_pkg::REG_BASE_D:   cfg_q.base_d   <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end: accept and classify
	pbd_front u_front (
		.start (start),
		.cmd   (cmd),
		.full  (qstat.full),
		.busy  (busy),
		.push  (push),
		.job   (push_job)
	);

	// decoupling queue
	pbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.stat     (qstat)
	);

	// back end: philox rounds, rejection and remainder
	pbd_back #(
		.ROUND_COUNT  (ROUND_COUNT),
		.RETRY_BLOCKS (RETRY_BLOCKS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.qstat  (qstat),
		.q_job  (pop_job),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

	// result strobes never come back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back result strobes");

	// failed draws carry a zero value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != pbd_pkg::ST_OK) |-> result.draw_value == 32'd0)
		else $error("non-zero value with failure status");

	// the queue never pops while empty
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.valid) else $error("pop from empty queue");

endmodule

// ===== hdl/pbd_front.sv =====
module pbd_front (
	input  logic            start,
	input  pbd_pkg::cmd_t   cmd,
	input  logic            full,
	output logic            busy,
	output logic            push,
	output pbd_pkg::job_t   job
);

	assign busy = full;
	assign push = start && !full;

	// sort items so the back end knows the path at once
	always_comb begin
		job.cmd = cmd;
		if (cmd.operation == pbd_pkg::OP_RAW) begin
			job.cls = pbd_pkg::CLS_RAW;
		end else if (cmd.draw_limit == 32'd0) begin
			job.cls = pbd_pkg::CLS_ZERO;
		end else begin
			job.cls = pbd_pkg::CLS_BOUNDED;
		end
	end

endmodule

// ===== hdl/pbd_queue.sv =====
module pbd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pbd_pkg::job_t    push_job,
	input  logic             pop,
	output pbd_pkg::job_t    pop_job,
	output pbd_pkg::qstat_t  stat
);

	pbd_pkg::job_t mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	assign stat.valid = cnt_q != 2'd0;
	assign stat.full  = cnt_q == 2'd2;
	assign pop_job    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== hdl/pbd_div.sv =====
module pbd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] remainder
);

	logic [31:0] rem_q;
	logic [32:0] dvd_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;

	// one quotient bit a cycle, restoring
	assign trial = {rem_q, dvd_q[32]};
	assign diff  = trial - {1'b0, dsr_q};

	assign done      = done_q;
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 32'd0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= diff[32] ? trial[31:0] : diff[31:0];
			dvd_q <= {dvd_q[31:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= 6'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd32) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hdl/pbd_back.sv =====
module pbd_back #(
	parameter int unsigned ROUND_COUNT  = pbd_pkg::ROUND_COUNT_DEF,
	parameter int unsigned RETRY_BLOCKS = pbd_pkg::RETRY_BLOCKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pbd_pkg::cfg_t     cfg,
	input  pbd_pkg::qstat_t   qstat,
	input  pbd_pkg::job_t     q_job,
	output logic              pop,
	output logic              done,
	output pbd_pkg::result_t  result
);

	localparam int unsigned RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam int unsigned BW = (RETRY_BLOCKS > 1) ? $clog2(RETRY_BLOCKS) : 1;
	localparam logic [RW-1:0] RND_LAST = RW'(ROUND_COUNT - 1);
	localparam logic [BW-1:0] BLK_LAST = BW'(RETRY_BLOCKS - 1);

	pbd_pkg::state_t state_q, state_d;
	pbd_pkg::job_t   job_q;
	logic [31:0]     v_q [4];
	logic [31:0]     k0_q, k1_q;
	logic [RW-1:0]   rnd_q;
	logic [BW-1:0]   blk_q;
	logic [31:0]     thr_q;
	logic [31:0]     val_q;
	logic [1:0]      st_q;

	logic [63:0]     p0, p1;
	logic            hit;
	logic [31:0]     hit_val;
	logic            div_start;
	logic [32:0]     div_dvd;
	logic [31:0]     div_dsr;
	logic            div_done;
	logic [31:0]     div_rem;
	pbd_pkg::cmd_t   cur;

	pbd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.remainder (div_rem)
	);

	assign p0 = 64'(pbd_pkg::MULT_A) * 64'(v_q[0]);
	assign p1 = 64'(pbd_pkg::MULT_B) * 64'(v_q[2]);
	assign cur = job_q.cmd;

	// first lane at or above the threshold
	always_comb begin
		hit     = 1'b0;
		hit_val = v_q[3];
		for (int i = 3; i >= 0; i--) begin
			if (v_q[i] >= thr_q) begin
				hit     = 1'b1;
				hit_val = v_q[i];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pbd_pkg::S_IDLE: begin
				if (qstat.valid) begin
					unique case (q_job.cls)
						pbd_pkg::CLS_RAW:  state_d = pbd_pkg::S_ROUND;
						pbd_pkg::CLS_ZERO: state_d = pbd_pkg::S_OUT;
						default:           state_d = pbd_pkg::S_THR;
					endcase
				end
			end
			pbd_pkg::S_THR: if (div_done) state_d = pbd_pkg::S_ROUND;
			pbd_pkg::S_ROUND: if (rnd_q == RND_LAST) state_d = pbd_pkg::S_PICK;
			pbd_pkg::S_PICK: begin
				if (job_q.cls == pbd_pkg::CLS_RAW) begin
					state_d = pbd_pkg::S_OUT;
				end else if (hit) begin
					state_d = pbd_pkg::S_MOD;
				end else if (blk_q == BLK_LAST) begin
					state_d = pbd_pkg::S_OUT;
				end else begin
					state_d = pbd_pkg::S_ROUND;
				end
			end
			pbd_pkg::S_MOD: if (div_done) state_d = pbd_pkg::S_OUT;
			pbd_pkg::S_OUT: state_d = pbd_pkg::S_IDLE;
			default: state_d = pbd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		done      = 1'b0;
		div_start = 1'b0;
		div_dvd   = {1'b0, hit_val};
		div_dsr   = cur.draw_limit;
		unique case (state_q)
			pbd_pkg::S_IDLE: begin
				pop       = qstat.valid;
				div_start = qstat.valid && (q_job.cls == pbd_pkg::CLS_BOUNDED);
				div_dvd   = 33'h1_0000_0000;
				div_dsr   = q_job.cmd.draw_limit;
			end
			pbd_pkg::S_PICK: begin
				div_start = (job_q.cls != pbd_pkg::CLS_RAW) && hit;
			end
			pbd_pkg::S_OUT: done = 1'b1;
			default: ;
		endcase
	end

	assign result.draw_value = val_q;
	assign result.status     = st_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			pbd_pkg::S_IDLE: begin
				job_q <= q_job;
				blk_q <= '0;
				rnd_q <= '0;
				val_q <= 32'd0;
				st_q  <= (q_job.cls == pbd_pkg::CLS_ZERO) ? pbd_pkg::ST_ZERO : pbd_pkg::ST_OK;
				k0_q  <= cfg.key_low;
				k1_q  <= cfg.key_high;
				v_q[0] <= cfg.base_a ^ q_job.cmd.sample_index[31:0];
				v_q[1] <= cfg.base_b ^ q_job.cmd.sample_index[63:32];
				v_q[2] <= cfg.base_c ^ q_job.cmd.draw_site;
				v_q[3] <= cfg.base_d;
			end
			pbd_pkg::S_THR: begin
				if (div_done) begin
					thr_q <= div_rem;
				end
			end
			pbd_pkg::S_ROUND: begin
				v_q[0] <= p1[63:32] ^ v_q[1] ^ k0_q;
				v_q[1] <= p1[31:0];
				v_q[2] <= p0[63:32] ^ v_q[3] ^ k1_q;
				v_q[3] <= p0[31:0];
				k0_q   <= k0_q + pbd_pkg::WEYL_A;
				k1_q   <= k1_q + pbd_pkg::WEYL_B;
				rnd_q  <= (rnd_q == RND_LAST) ? '0 : rnd_q + RW'(1);
			end
			pbd_pkg::S_PICK: begin
				if (job_q.cls == pbd_pkg::CLS_RAW) begin
					val_q <= v_q[cur.sample_index[1:0]];
				end else if (!hit) begin
					if (blk_q == BLK_LAST) begin
						st_q <= pbd_pkg::ST_EXHAUSTED;
					end
					// next retry block starts from a fresh counter
					blk_q  <= blk_q + BW'(1);
					k0_q   <= cfg.key_low;
					k1_q   <= cfg.key_high;
					v_q[0] <= cfg.base_a ^ cur.sample_index[31:0];
					v_q[1] <= cfg.base_b ^ cur.sample_index[63:32];
					v_q[2] <= cfg.base_c ^ cur.draw_site;
					v_q[3] <= cfg.base_d ^ 32'(blk_q + BW'(1));
				end
			end
			pbd_pkg::S_MOD: begin
				if (div_done) begin
					val_q <= div_rem;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== test/pbd_checker.sv =====
module pbd_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  pbd_pkg::cmd_t                 cmd,
	input  logic                          done,
	input  pbd_pkg::result_t              result,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [pbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output int                            fail_count,
	output int                            pending
);

	logic [31:0] key_lo, key_hi, base_a, base_b, base_c, base_d;
	pbd_pkg::result_t draw_queue[$];

	assign pending = draw_queue.size();

	function automatic logic [127:0] philox_mix(logic [31:0] c0, c1, c2, c3);
		logic [31:0] v0, v1, v2, v3, k0, k1;
		logic [63:0] p0, p1;
		v0 = c0; v1 = c1; v2 = c2; v3 = c3;
		k0 = key_lo; k1 = key_hi;
		for (int r = 0; r < pbd_pkg::ROUND_COUNT_DEF; r++) begin
			p0 = 64'(pbd_pkg::MULT_A) * 64'(v0);
			p1 = 64'(pbd_pkg::MULT_B) * 64'(v2);
			v0 = p1[63:32] ^ v1 ^ k0;
			v1 = p1[31:0];
			v2 = p0[63:32] ^ v3 ^ k1;
			v3 = p0[31:0];
			k0 += pbd_pkg::WEYL_A;
			k1 += pbd_pkg::WEYL_B;
		end
		return {v3, v2, v1, v0};
	endfunction

	function automatic pbd_pkg::result_t draw_predict(pbd_pkg::cmd_t c);
		pbd_pkg::result_t res;
		logic [127:0] lanes;
		logic [31:0] thr, lane_val;
		bit found;
		res = '0;
		found = 0;
		if (c.operation == pbd_pkg::OP_RAW) begin
			lanes = philox_mix(base_a ^ c.sample_index[31:0], base_b ^ c.sample_index[63:32],
				base_c ^ c.draw_site, base_d);
			res.draw_value = lanes[32*c.sample_index[1:0] +: 32];
			res.status = pbd_pkg::ST_OK;
		end else if (c.draw_limit == 0) begin
			res.status = pbd_pkg::ST_ZERO;
		end else begin
			thr = 32'((64'd1 << 32) % 64'(c.draw_limit));
			for (int b = 0; b < pbd_pkg::RETRY_BLOCKS_DEF && !found; b++) begin
				lanes = philox_mix(base_a ^ c.sample_index[31:0],
					base_b ^ c.sample_index[63:32], base_c ^ c.draw_site, base_d ^ 32'(b));
				for (int l = 0; l < 4 && !found; l++) begin
					lane_val = lanes[32*l +: 32];
					if (lane_val >= thr) begin
						res.draw_value = lane_val % c.draw_limit;
						found = 1;
					end
				end
			end
			if (!found) res.status = pbd_pkg::ST_EXHAUSTED;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pbd_pkg::result_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			key_lo <= '0; key_hi <= '0;
			base_a <= '0; base_b <= '0; base_c <= '0; base_d <= '0;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pbd_pkg::REG_KEY_LOW:  key_lo <= cfg_data;
					pbd_pkg::REG_KEY_HIGH: key_hi <= cfg_data;
					pbd_pkg::REG_BASE_A:   base_a <= cfg_data;
					pbd_pkg::REG_BASE_B:   base_b <= cfg_data;
					pbd_pkg::REG_BASE_C:   base_c <= cfg_data;
					pbd_pkg::REG_BASE_D:   base_d <= cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				draw_queue.push_back(draw_predict(cmd));
			if (done) begin
				if (draw_queue.size() == 0) begin
					$error("unexpected result value=%h status=%0d", result.draw_value,
						result.status);
					errs++;
				end else begin
					want = draw_queue.pop_front();
					if (want.draw_value !== result.draw_value) begin
						$error("draw_value expected %h actual %h", want.draw_value,
							result.draw_value);
						errs++;
					end
					if (want.status !== result.status) begin
						$error("status expected %0d actual %0d", want.status, result.status);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end
endmodule

// ===== test/tb.sv =====
module tb;

	logic clk, arst_n, start, busy, done, cfg_valid, cfg_ready;
	pbd_pkg::cmd_t cmd;
	pbd_pkg::result_t result;
	logic [pbd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	int fail_count, pending;
	longint cycle_count = 0;

	philox_bounded_draw_unit i_dut (
		.clk, .arst_n, .start, .busy, .cmd, .done, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	pbd_checker i_checker (
		.clk, .arst_n, .start, .busy, .cmd, .done, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// watchdog: worst case is ~450 items each exhausting every retry block
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd8_000_000) begin
			$display("philox_bounded_draw_unit: mismatch");
			$finish;
		end
	end

	// one register write, only ever done while the unit is drained
	task automatic reg_write(pbd_pkg::reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// send one item; start stays high across back-to-back items
	task automatic send_item(logic op, logic [63:0] idx, logic [31:0] site,
		logic [31:0] bound, bit gaps);
		int gap;
		gap = gaps ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14)) : 0;
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(negedge clk);
		end
		start <= 1;
		cmd <= '{operation: op, sample_index: idx, draw_site: site, draw_limit: bound};
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// wait for every expected result, then let the engine settle
	task automatic drain();
		start <= 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// a fresh key and counter base; the extremes come first
	task automatic load_config(int mode);
		for (int r = 0; r < 6; r++)
			reg_write(pbd_pkg::reg_idx_t'(r),
				mode == 0 ? 32'h0 : mode == 1 ? 32'hffffffff : $urandom());
		if (mode > 1) reg_write(pbd_pkg::reg_idx_t'($urandom_range(0, 5)), $urandom());
		cfg_valid <= 0;
		cfg_index <= 3'd6;
	endtask

	function automatic logic [31:0] rand_bound();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hffffffff;
			3: return 32'h80000001;
			4: return $urandom_range(2, 16);
			5: return 32'h80000000 | $urandom();
			default: return $urandom();
		endcase
	endfunction

	initial begin
		start = 0; cmd = '0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: every operation, bound extremes, lane choice, index and site extremes
		send_item(pbd_pkg::OP_RAW, 64'h0, 32'h0, 32'h0, 0);
		for (int l = 1; l < 4; l++) send_item(pbd_pkg::OP_RAW, 64'(l), 32'h0, 32'h5, 0);
		send_item(pbd_pkg::OP_RAW, '1, '1, '1, 0);
		send_item(pbd_pkg::OP_BOUNDED, 64'h0, 32'h0, 32'h0, 0);
		send_item(pbd_pkg::OP_BOUNDED, '1, '1, 32'h1, 0);
		send_item(pbd_pkg::OP_BOUNDED, 64'h1, 32'h7, 32'hffffffff, 1);
		send_item(pbd_pkg::OP_BOUNDED, 64'h2, 32'h7, 32'h80000001, 1);
		send_item(pbd_pkg::OP_BOUNDED, 64'h3, 32'h7, 32'h80000000, 1);
		send_item(pbd_pkg::OP_BOUNDED, 64'h4, 32'h9, 32'd3, 1);
		send_item(pbd_pkg::OP_BOUNDED, 64'h5, '1, 32'd7, 1);
		drain();

		// random: several configurations, extremes first
		for (int phase = 0; phase < 6; phase++) begin
			load_config(phase);
			for (int n = 0; n < 75; n++)
				send_item(logic'($urandom_range(0, 1)), {$urandom(), $urandom()}, $urandom(),
					rand_bound(), n % 25 < 18);
			drain();
		end

		if (fail_count == 0)
			$display("philox_bounded_draw_unit: match");
		else
			$display("philox_bounded_draw_unit: mismatch");
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/pbd_pkg.sv
hdl/pbd_front.sv
hdl/pbd_queue.sv
hdl/pbd_div.sv
hdl/pbd_back.sv
hdl/philox_bounded_draw_unit.sv
test/pbd_checker.sv
test/tb.sv
